@@ design/msp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-stack shared pool package
// Word types, operation and status codes, and default sizes shared by the
// controller, the datapath, the top level and the port checker.
// ----------------------------------------------------------------------------
package msp_pkg;

    // Default sizes for the top-level parameters.
    localparam int NUM_STACKS_DEF   = 8;
    localparam int POOL_ENTRIES_DEF = 64;

    // Fixed field widths.
    localparam int VALUE_W = 32;
    localparam int SID_W   = 3;

    // Value returned by a pop that finds its stack empty.
    localparam logic signed [VALUE_W-1:0] FAIL_VALUE = -32'sd1;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        t_op                        op;
        logic [SID_W-1:0]           stack_id;
        logic signed [VALUE_W-1:0]  push_value;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  pop_value;
        t_status                    status;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // take the input word and start the memory reads
        logic commit;   // write back the pointers and load the result word
    } t_cmd;

endpackage
`default_nettype wire

@@ design/multi_stack_shared_pool.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-stack shared pool
// Several LIFO stacks that share one pool of entries linked by next
// pointers, with unused entries kept on a free list.
// ----------------------------------------------------------------------------
// Usage:
// Each input word is a push (value onto the named stack) or a pop (top value
// of the named stack). Every input word yields exactly one output word that
// carries the popped value and a status: ok, overflow when a push finds no
// free entry, or empty when a pop finds nothing. A failed pop returns -1 and
// every push returns 0. Stack numbers at or above NUM_STACKS behave as always
// empty and always full.
// An accepted word reads its head pointer and starts the synchronous reads of
// the link and value memories; the commit, once the output register is free,
// writes the pointers back and loads the output register. The block takes no
// new word until the previous one has committed, a limit set by the
// read-then-write turn on the link memory.
// Reset empties every stack and puts all entries on the free list at once:
// a fill count stands in for the initial link chain, so no clearing pass is
// run and a word may be offered in the first cycle after reset.
// The output word sits in a register. A new input word can be accepted while
// it waits; if the receiver still stalls when that next result is ready, the
// block holds it internally and keeps o_in_stall high until the register
// frees.
// ----------------------------------------------------------------------------
module multi_stack_shared_pool
    import msp_pkg::*;
#(
    parameter int NUM_STACKS   = NUM_STACKS_DEF,
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    // Command path from the sequencer into the datapath.
    t_cmd cmd;

    // The controller only sequences; it never looks at the payload.
    msp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // All pointer and memory state lives in the datapath.
    msp_datapath #(
        .NUM_STACKS   (NUM_STACKS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .o_out_word (o_out_word)
    );

endmodule
`default_nettype wire

@@ design/msp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-stack shared pool controller
// Two-state sequencer: accept a word, then commit it once the output
// register can take the result.
// ----------------------------------------------------------------------------
module msp_ctrl
    import msp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_cmd      o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_in_stall;
    logic   r_out_valid;
    logic   out_free;

    always_comb begin
        out_free     = !r_out_valid || !i_out_stall;
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.commit = (r_state == S_EXEC) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_EXEC;
                        r_in_stall <= 1'b1;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_state    <= S_IDLE;
                        r_in_stall <= 1'b0;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_stall <= 1'b0;
                end
            endcase

            if (o_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = r_in_stall;
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

@@ design/msp_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-stack shared pool datapath
// Value and link memories, stack head pointers, free-list head, fill count
// and the result register.
// ----------------------------------------------------------------------------
module msp_datapath
    import msp_pkg::*;
#(
    parameter int NUM_STACKS   = NUM_STACKS_DEF,
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cmd     i_cmd,
    input  wire t_in_word i_in_word,
    output t_out_word     o_out_word
);

    // A pointer also needs the null code, which is POOL_ENTRIES.
    localparam int PTR_W  = $clog2(POOL_ENTRIES + 1);
    localparam int IDX_W  = $clog2(POOL_ENTRIES);
    // Only stack numbers the field can carry get a head register.
    localparam int HEADS  = (NUM_STACKS < (1 << SID_W)) ? NUM_STACKS : (1 << SID_W);
    localparam int HSEL_W = (HEADS > 1) ? $clog2(HEADS) : 1;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_ENTRIES);

    logic [PTR_W-1:0]          r_heads [HEADS];
    logic [PTR_W-1:0]          r_free_head;
    logic [PTR_W-1:0]          r_fill;

    logic signed [VALUE_W-1:0] mem_val  [POOL_ENTRIES];
    logic [PTR_W-1:0]          mem_link [POOL_ENTRIES];
    logic signed [VALUE_W-1:0] r_val_q;
    logic [PTR_W-1:0]          r_link_q;

    t_op                       r_op;
    logic [HSEL_W-1:0]         r_hsel;
    logic                      r_ok;
    logic [PTR_W-1:0]          r_ptr;
    logic signed [VALUE_W-1:0] r_push_value;
    t_out_word                 r_out;

    logic                      sid_ok;
    logic [HSEL_W-1:0]         hsel;
    logic [PTR_W-1:0]          n_ptr;
    logic                      n_ok;
    logic [IDX_W-1:0]          rd_addr;
    logic [IDX_W-1:0]          wr_addr;
    logic                      fresh;
    logic [PTR_W-1:0]          link;

    always_comb begin
        sid_ok  = int'(i_in_word.stack_id) < NUM_STACKS;
        hsel    = sid_ok ? i_in_word.stack_id[HSEL_W-1:0] : '0;
        n_ptr   = (i_in_word.op == OP_PUSH) ? r_free_head : r_heads[hsel];
        n_ok    = sid_ok && (n_ptr != NULL_PTR);
        rd_addr = n_ok ? n_ptr[IDX_W-1:0] : '0;
    end

    // Entries at or above the fill count have never been taken, so their link is
    // not read from the link memory but formed as the next entry.
    always_comb begin
        wr_addr = r_ptr[IDX_W-1:0];
        fresh   = r_ptr >= r_fill;
        link    = fresh ? (r_ptr + PTR_W'(1)) : r_link_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HEADS; k++) begin
                r_heads[k] <= NULL_PTR;
            end
            r_free_head <= '0;
            r_fill      <= '0;
        end else if (i_cmd.commit && r_ok) begin
            if (r_op == OP_PUSH) begin
                r_free_head     <= link;
                r_heads[r_hsel] <= r_ptr;
                if (fresh) begin
                    r_fill <= r_fill + PTR_W'(1);
                end
            end else begin
                r_heads[r_hsel] <= link;
                r_free_head     <= r_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_val_q  <= mem_val[rd_addr];
            r_link_q <= mem_link[rd_addr];
        end
        if (i_cmd.commit && r_ok) begin
            if (r_op == OP_PUSH) begin
                mem_val[wr_addr]  <= r_push_value;
                mem_link[wr_addr] <= r_heads[r_hsel];
            end else begin
                mem_link[wr_addr] <= r_free_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op         <= i_in_word.op;
            r_hsel       <= hsel;
            r_ok         <= n_ok;
            r_ptr        <= n_ptr;
            r_push_value <= i_in_word.push_value;
        end
        if (i_cmd.commit) begin
            if (r_op == OP_PUSH) begin
                r_out.pop_value <= '0;
                r_out.status    <= r_ok ? ST_OK : ST_OVERFLOW;
            end else begin
                r_out.pop_value <= r_ok ? r_val_q : FAIL_VALUE;
                r_out.status    <= r_ok ? ST_OK : ST_EMPTY;
            end
        end
    end

    assign o_out_word = r_out;

endmodule
`default_nettype wire

@@ design/msp_check.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-stack shared pool port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module msp_check
    import msp_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // A stalled result word does not change.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    // An accepted word keeps the block busy in the following cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted on two consecutive cycles");

    // A failed pop always carries the fail value.
    a_empty_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.status == ST_EMPTY)
            |-> (o_out_word.pop_value == FAIL_VALUE))
        else $error("empty status without fail value");

    // An overflowed push returns zero, and no unused status code appears.
    a_ovf_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.status == ST_OK) ||
            ((o_out_word.status == ST_OVERFLOW) && (o_out_word.pop_value == '0)) ||
            (o_out_word.status == ST_EMPTY)))
        else $error("bad status or overflow value");

endmodule

bind multi_stack_shared_pool msp_check u_msp_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
`default_nettype wire
